/* rtl/core/rpe_pkg.sv */
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package rpe_pkg;

    // Characters recognised in the input stream.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    localparam int DATA_W  = 32;
    localparam int OUT_W   = 40;
    localparam int DIV_STEPS = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    // One command from the front to the back, executed in field order:
    // push, then operator, then end of expression.
    typedef struct packed {
        logic              push;
        logic [DATA_W-1:0] value;
        logic              op_valid;
        t_op               op;
        logic              last;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PUSH,
        BS_OPRD,
        BS_RD2,
        BS_EXEC,
        BS_DIV,
        BS_END,
        BS_RDB
    } t_bstate;

endpackage

/* rtl/core/postfix_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates ASCII postfix expressions received one character per transaction.
// ----------------------------------------------------------------------------
// Input stream: i_s_tdata carries one character, i_s_tlast marks the last
// character of an expression. Digits build a decimal number, a space or an
// operator pushes it, and + - * / work on the two top stack entries.
// Output stream: one transaction per expression, carrying the bottom stack
// entry and a status (ok, underflow, overflow, divide by zero).
// Characters are taken one a cycle while the command queue has room. A
// digit or an ignored character that does not close the expression ends
// there; any other character becomes a command, which the idle execution
// unit pops from the queue. A command passes the push, operand read, second
// read and execute states; a push alone or too few operands end it after
// the operand read, and a divide waits in the one-bit-a-cycle divider.
// An expression end adds a read of the bottom entry for the output register.
// When the receiver stalls, the result is held in the output register; the
// execution unit stops at the next expression end and the queue then fills.
// Reset empties the queue and the stack and clears any held error.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,   // end_of_expr
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [31:0] value, [33:32] status, [39:34] zero
);

    rpe_pkg::t_cmd front_cmd, head_cmd;
    logic          q_push, q_pop, q_full, q_empty;

    rpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_char   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_cmd    (front_cmd)
    );

    rpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rpe_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata)
    );

endmodule

/* rtl/core/rpe_front.sv */
// ----------------------------------------------------------------------------
// rpe_front
// Accepts characters, builds decimal numbers and turns each character that
// ends a number, names an operator or closes the expression into a command.
// ----------------------------------------------------------------------------
module rpe_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    input  logic        i_q_full,
    output logic        o_q_push,
    output rpe_pkg::t_cmd o_cmd
);

    logic [rpe_pkg::DATA_W-1:0] r_acc, n_acc;
    logic                       r_pend, n_pend;

    logic is_digit, is_space, is_op, flush, accept;
    logic [rpe_pkg::DATA_W-1:0] acc_dig;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign is_digit = i_char inside {[rpe_pkg::CH_ZERO:rpe_pkg::CH_NINE]};
    assign is_space = (i_char == rpe_pkg::CH_SPACE);
    assign is_op    = i_char inside {rpe_pkg::CH_PLUS, rpe_pkg::CH_MINUS,
                                     rpe_pkg::CH_STAR, rpe_pkg::CH_SLASH};

    // Times ten as two shifts and an add, wrapping at the data width.
    assign acc_dig = (r_acc << 3) + (r_acc << 1) +
                     rpe_pkg::DATA_W'(i_char - rpe_pkg::CH_ZERO);

    assign flush = is_space || is_op || i_last;

    always_comb begin
        o_cmd          = '0;
        o_cmd.value    = is_digit ? acc_dig : r_acc;
        o_cmd.push     = flush && (is_digit || r_pend);
        o_cmd.op_valid = is_op;
        o_cmd.last     = i_last;
        case (i_char)
            rpe_pkg::CH_PLUS:  o_cmd.op = rpe_pkg::OP_ADD;
            rpe_pkg::CH_MINUS: o_cmd.op = rpe_pkg::OP_SUB;
            rpe_pkg::CH_STAR:  o_cmd.op = rpe_pkg::OP_MUL;
            default:           o_cmd.op = rpe_pkg::OP_DIV;
        endcase
        o_q_push = accept && (o_cmd.push || is_op || i_last);

        n_acc  = r_acc;
        n_pend = r_pend;
        if (accept) begin
            if (flush) begin
                n_acc  = '0;
                n_pend = 1'b0;
            end else if (is_digit) begin
                n_acc  = acc_dig;
                n_pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

endmodule

/* rtl/core/rpe_queue.sv */
// ----------------------------------------------------------------------------
// rpe_queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module rpe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output rpe_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    rpe_pkg::t_cmd                 r_mem [rpe_pkg::QDEPTH];
    logic [rpe_pkg::QAW-1:0]       r_wr, r_rd;
    logic [rpe_pkg::QCW-1:0]       r_cnt;

    assign o_full  = (r_cnt == rpe_pkg::QCW'(rpe_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + rpe_pkg::QCW'(i_push) - rpe_pkg::QCW'(i_pop);
        end
    end

endmodule

/* rtl/core/rpe_div.sv */
// ----------------------------------------------------------------------------
// rpe_div
// Iterative signed divider truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rpe_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpe_pkg::DATA_W-1:0] i_num,
    input  logic [rpe_pkg::DATA_W-1:0] i_den,
    output logic                       o_done,
    output logic [rpe_pkg::DATA_W-1:0] o_quo
);

    localparam int W = rpe_pkg::DATA_W;

    logic [W:0]   r_rem;
    logic [W-1:0] r_quo, r_den;
    logic [4:0]   r_cnt;
    logic         r_busy, r_done, r_neg;

    logic [W:0]   rem_sh, rem_sub;

    assign rem_sh  = {r_rem[W-1:0], r_quo[W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quo   = r_neg ? (W'(0) - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[W-1] ? (W'(0) - i_num) : i_num;
            r_den <= i_den[W-1] ? (W'(0) - i_den) : i_den;
            r_neg <= i_num[W-1] ^ i_den[W-1];
        end else if (r_busy) begin
            if (!rem_sub[W]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'(rpe_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/rpe_back.sv */
// ----------------------------------------------------------------------------
// rpe_back
// Executes commands against the operand stack and delivers the result of
// each expression through an output register.
// ----------------------------------------------------------------------------
module rpe_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  rpe_pkg::t_cmd             i_cmd,
    output logic                      o_q_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rpe_pkg::OUT_W-1:0] o_data
);

    localparam int W  = rpe_pkg::DATA_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [W-1:0]  r_stack [STACK_DEPTH];
    logic [W-1:0]  r_rdata, r_top;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [W-1:0]  wr_data;
    logic          wr_en;

    rpe_pkg::t_bstate r_state, n_state;
    rpe_pkg::t_cmd    r_cmd, n_cmd;
    rpe_pkg::t_status r_err, n_err;
    logic [DW-1:0]    r_depth, n_depth;
    logic [W-1:0]     n_top;
    logic             r_oval, n_oval;
    logic [rpe_pkg::OUT_W-1:0] r_odata, n_odata;

    logic             div_start, div_done;
    logic [W-1:0]     div_quo, alu;
    logic [DW-1:0]    depth_m1, depth_m2;
    logic             out_free;

    rpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_rdata),
        .i_den   (r_top),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);
    assign out_free = !r_oval || i_ready;
    assign o_valid  = r_oval;
    assign o_data   = r_odata;

    // Second operand in r_rdata, top operand in r_top.
    always_comb begin
        case (r_cmd.op)
            rpe_pkg::OP_ADD: alu = r_rdata + r_top;
            rpe_pkg::OP_SUB: alu = r_rdata - r_top;
            rpe_pkg::OP_MUL: alu = r_rdata * r_top;
            default:         alu = div_quo;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_err     = r_err;
        n_depth   = r_depth;
        n_top     = r_top;
        n_oval    = r_oval && !i_ready;
        n_odata   = r_odata;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        rd_addr   = '0;
        wr_addr   = depth_m2[AW-1:0];
        wr_data   = alu;
        wr_en     = 1'b0;

        case (r_state)
            rpe_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = rpe_pkg::BS_PUSH;
                end
            end
            rpe_pkg::BS_PUSH: begin
                if (r_cmd.push) begin
                    if (r_depth >= DW'(STACK_DEPTH)) begin
                        if (r_err == rpe_pkg::ST_OK) n_err = rpe_pkg::ST_OVER;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_depth[AW-1:0];
                        wr_data = r_cmd.value;
                        n_depth = r_depth + DW'(1);
                    end
                end
                n_state = rpe_pkg::BS_OPRD;
            end
            rpe_pkg::BS_OPRD: begin
                rd_addr = depth_m1[AW-1:0];
                if (!r_cmd.op_valid) begin
                    n_state = rpe_pkg::BS_END;
                end else if (r_depth < DW'(2)) begin
                    if (r_err == rpe_pkg::ST_OK) n_err = rpe_pkg::ST_UNDER;
                    n_state = rpe_pkg::BS_END;
                end else begin
                    n_state = rpe_pkg::BS_RD2;
                end
            end
            rpe_pkg::BS_RD2: begin
                n_top   = r_rdata;
                rd_addr = depth_m2[AW-1:0];
                n_state = rpe_pkg::BS_EXEC;
            end
            rpe_pkg::BS_EXEC: begin
                if (r_cmd.op == rpe_pkg::OP_DIV) begin
                    if (r_top == '0) begin
                        if (r_err == rpe_pkg::ST_OK) n_err = rpe_pkg::ST_DIVZ;
                        n_state = rpe_pkg::BS_END;
                    end else begin
                        div_start = 1'b1;
                        n_state   = rpe_pkg::BS_DIV;
                    end
                end else begin
                    wr_en   = 1'b1;
                    n_depth = depth_m1;
                    n_state = rpe_pkg::BS_END;
                end
            end
            rpe_pkg::BS_DIV: begin
                if (div_done) begin
                    wr_en   = 1'b1;
                    n_depth = depth_m1;
                    n_state = rpe_pkg::BS_END;
                end
            end
            rpe_pkg::BS_END: begin
                rd_addr = '0;
                n_state = r_cmd.last ? rpe_pkg::BS_RDB : rpe_pkg::BS_IDLE;
            end
            rpe_pkg::BS_RDB: begin
                // The bottom entry is read again here so that it stays in r_rdata.
                rd_addr = '0;
                if (out_free) begin
                    n_oval = 1'b1;
                    if (r_depth == '0) begin
                        n_odata = {6'b0,
                                   (r_err == rpe_pkg::ST_OK) ? rpe_pkg::ST_UNDER : r_err,
                                   W'(0)};
                    end else begin
                        n_odata = {6'b0, r_err, r_rdata};
                    end
                    n_depth = '0;
                    n_err   = rpe_pkg::ST_OK;
                    n_state = rpe_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = rpe_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        r_rdata <= r_stack[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_top   <= n_top;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpe_pkg::BS_IDLE;
            r_err   <= rpe_pkg::ST_OK;
            r_depth <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
            r_depth <= n_depth;
            r_oval  <= n_oval;
        end
    end

endmodule

/* rtl/core/rpe_checker.sv */
// ----------------------------------------------------------------------------
// rpe_checker
// Port-level checks of the postfix expression evaluator, bound to the top.
// ----------------------------------------------------------------------------
module rpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    // A stalled result transaction must stay offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result pending and an empty queue ready for input.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[39:34] == 6'b0))
        else $error("padding bits of result not zero");

endmodule

bind postfix_expression_evaluator rpe_checker u_rpe_checker (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the postfix expression evaluator.
// ----------------------------------------------------------------------------
// Characters are queued by an initial block and sent by a clocked driver. A
// monitor predicts each expression result as characters are accepted and
// compares every output transaction with the oldest prediction. A short
// directed list of expressions comes first. Random well-formed expressions
// follow, mixed with broken sequences, raw byte noise, stack overflow runs
// and the most negative value divided by minus one. Both sides idle at random.
// The receiver also holds off for long stretches, and the sender pauses now
// and then until every predicted result has arrived.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CALC_DEPTH  = 32;
    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 100;
    localparam int LONG_HOLD   = 1000;

    typedef struct {
        logic [7:0] code;
        logic       last;
        logic       hold;
    } t_char_item;

    typedef struct {
        logic [31:0]      value;
        rpe_pkg::t_status status;
    } t_answer;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'd0;   // [7:0] char_code
    logic        i_s_tlast  = 1'b0;   // end_of_expr
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;           // [31:0] value, [33:32] status, [39:34] zero

    postfix_expression_evaluator #(
        .STACK_DEPTH(CALC_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Expression predictor
    // ------------------------------------------------------------------------
    logic [31:0]      calc_stack [CALC_DEPTH];
    int               calc_depth   = 0;
    logic [31:0]      calc_accum   = '0;
    logic             calc_pending = 1'b0;
    rpe_pkg::t_status calc_err     = rpe_pkg::ST_OK;
    t_answer          answer_q [$];

    function automatic logic [31:0] quot_trunc(logic [31:0] n, logic [31:0] d);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] q;
        mag_n = n[31] ? -n : n;
        mag_d = d[31] ? -d : d;
        q     = mag_n / mag_d;
        return (n[31] ^ d[31]) ? -q : q;
    endfunction

    // Only the first error of an expression is kept.
    task automatic calc_error(rpe_pkg::t_status code);
        if (calc_err == rpe_pkg::ST_OK)
            calc_err = code;
    endtask

    task automatic calc_push(logic [31:0] v);
        if (calc_depth >= CALC_DEPTH) begin
            calc_error(rpe_pkg::ST_OVER);
        end else begin
            calc_stack[calc_depth] = v;
            calc_depth++;
        end
    endtask

    task automatic calc_flush();
        if (calc_pending)
            calc_push(calc_accum);
        calc_accum   = '0;
        calc_pending = 1'b0;
    endtask

    task automatic calc_operator(logic [7:0] c);
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] r;
        if (calc_depth < 2) begin
            calc_error(rpe_pkg::ST_UNDER);
            return;
        end
        t = calc_stack[calc_depth-1];
        s = calc_stack[calc_depth-2];
        case (c)
            rpe_pkg::CH_PLUS:  r = s + t;
            rpe_pkg::CH_MINUS: r = s - t;
            rpe_pkg::CH_STAR:  r = s * t;
            default: begin
                if (t == '0) begin
                    calc_error(rpe_pkg::ST_DIVZ);
                    return;
                end
                r = quot_trunc(s, t);
            end
        endcase
        calc_depth--;
        calc_stack[calc_depth-1] = r;
    endtask

    task automatic calc_char(logic [7:0] c, logic last);
        t_answer a;
        if (c >= rpe_pkg::CH_ZERO && c <= rpe_pkg::CH_NINE) begin
            calc_accum   = calc_accum * 32'd10 + {24'd0, c - rpe_pkg::CH_ZERO};
            calc_pending = 1'b1;
        end else if (c == rpe_pkg::CH_SPACE) begin
            calc_flush();
        end else if (c == rpe_pkg::CH_PLUS || c == rpe_pkg::CH_MINUS ||
                     c == rpe_pkg::CH_STAR || c == rpe_pkg::CH_SLASH) begin
            calc_flush();
            calc_operator(c);
        end
        if (last) begin
            calc_flush();
            a.status = calc_err;
            if (calc_depth > 0) begin
                a.value = calc_stack[0];
            end else begin
                a.value = '0;
                if (a.status == rpe_pkg::ST_OK)
                    a.status = rpe_pkg::ST_UNDER;
            end
            answer_q.push_back(a);
            calc_depth = 0;
            calc_err   = rpe_pkg::ST_OK;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    t_char_item char_q [$];
    int         char_total = 0;
    logic       hold_next  = 1'b0;

    task automatic send_char(logic [7:0] c);
        char_q.push_back('{c, 1'b0, hold_next});
        hold_next = 1'b0;
        char_total++;
    endtask

    task automatic close_expr();
        char_q[char_q.size()-1].last = 1'b1;
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i]);
        close_expr();
    endtask

    function automatic logic [7:0] pick_op();
        logic [7:0] ops [4];
        ops = '{rpe_pkg::CH_PLUS, rpe_pkg::CH_MINUS, rpe_pkg::CH_STAR, rpe_pkg::CH_SLASH};
        return ops[$urandom_range(0, 3)];
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= rpe_pkg::CH_ZERO && c <= rpe_pkg::CH_NINE) ||
               c == rpe_pkg::CH_SPACE || c == rpe_pkg::CH_PLUS ||
               c == rpe_pkg::CH_MINUS || c == rpe_pkg::CH_STAR ||
               c == rpe_pkg::CH_SLASH);
        return c;
    endfunction

    // Mostly short numbers so that divisions stay meaningful; long digit
    // strings wrap the accumulator.
    task automatic send_number();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            send_char(rpe_pkg::CH_ZERO);
        end else begin
            n = (kind < 7) ? $urandom_range(1, 2) : $urandom_range(3, 11);
            for (int i = 0; i < n; i++)
                send_char(rpe_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic send_wellformed();
        int   operands;
        int   held;
        logic prev_num;
        operands = $urandom_range(1, 6);
        held     = 0;
        prev_num = 1'b0;
        while (operands > 0 || held > 1) begin
            if (held >= 2 && (operands == 0 || $urandom_range(0, 1) == 1)) begin
                if ($urandom_range(0, 1) == 1)
                    send_char(rpe_pkg::CH_SPACE);
                send_char(pick_op());
                held--;
                prev_num = 1'b0;
            end else begin
                if (prev_num || $urandom_range(0, 3) == 0)
                    send_char(rpe_pkg::CH_SPACE);
                send_number();
                operands--;
                held++;
                prev_num = 1'b1;
            end
            if ($urandom_range(0, 15) == 0)
                send_char(junk_char());
        end
        if ($urandom_range(0, 3) == 0)
            send_char(rpe_pkg::CH_SPACE);
        close_expr();
    endtask

    task automatic send_broken();
        int n;
        int pick;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_char(rpe_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            else if (pick < 6)
                send_char(rpe_pkg::CH_SPACE);
            else if (pick < 9)
                send_char(pick_op());
            else
                send_char(junk_char());
        end
        close_expr();
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_char(8'($urandom_range(0, 255)));
        close_expr();
    endtask

    // More pushes than the stack holds, then a few operators on what is left.
    task automatic send_overflow();
        int n;
        n = $urandom_range(CALC_DEPTH + 1, CALC_DEPTH + 4);
        for (int i = 0; i < n; i++) begin
            send_char(rpe_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
            send_char(rpe_pkg::CH_SPACE);
        end
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            send_char(pick_op());
        close_expr();
    endtask

    // ------------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------------
    logic char_taken   = 1'b0;
    logic result_taken = 1'b0;
    int   results_seen = 0;
    int   send_gap     = 0;
    int   send_burst   = 0;
    int   recv_gap     = 0;
    int   recv_burst   = 0;
    int   hold_left    = 0;
    int   err_count    = 0;
    int   cycle_count  = 0;

    // Picks a random wait, with occasional stretches of no waiting.
    function automatic int pick_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || char_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_s_tvalid <= 1'b0;
            end else if (char_q.size() != 0 && (!char_q[0].hold || answer_q.size() == 0)) begin
                i_s_tdata  <= char_q[0].code;
                i_s_tlast  <= char_q[0].last;
                i_s_tvalid <= 1'b1;
                void'(char_q.pop_front());
                send_gap = pick_wait(send_burst);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // The long hold-offs let the command queue fill and stall the input.
    always @(negedge i_clk) begin
        if (result_taken) begin
            recv_gap = pick_wait(recv_burst);
            if (results_seen == 30 || results_seen == 90)
                hold_left = LONG_HOLD;
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(string msg);
        err_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        char_taken   = 1'b0;
        result_taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                char_taken = 1'b1;
                calc_char(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                result_taken = 1'b1;
                results_seen++;
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with none expected", o_m_tdata));
                end else begin
                    want = answer_q.pop_front();
                    if (o_m_tdata[31:0] !== want.value)
                        report_mismatch($sformatf("result %0d value %h, expected %h",
                                                  results_seen, o_m_tdata[31:0], want.value));
                    if (o_m_tdata[33:32] !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %s",
                                                  results_seen, o_m_tdata[33:32],
                                                  want.status.name()));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int kind;
        int expr_count;

        // Directed expressions: subtraction order with an operator straight
        // after digits, end straight after digits, divide by zero, underflow
        // on an empty stack, a lone space, ignored codes at both ends of the
        // byte range with extra entries left at the end, and a sticky error.
        send_text("7 3-");
        send_text("42");
        send_text("9 0/");
        send_text("+");
        send_text(" ");
        send_char(rpe_pkg::CH_ZERO + 8'd8);
        send_char(rpe_pkg::CH_SPACE);
        send_char(rpe_pkg::CH_ZERO + 8'd2);
        send_char(rpe_pkg::CH_SLASH);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(rpe_pkg::CH_ZERO + 8'd3);
        send_char(rpe_pkg::CH_SPACE);
        close_expr();
        send_text("1+2 0/");

        expr_count = 0;
        while (char_total < ITEM_TARGET) begin
            expr_count++;
            if (expr_count % 25 == 0)
                hold_next = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 70)
                send_wellformed();
            else if (kind < 82)
                send_broken();
            else if (kind < 92)
                send_noise();
            else if (kind < 96)
                send_overflow();
            else
                send_text("2147483648 0 1-/");
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Checked at the rising edge, where the driven inputs have settled.
        while (char_q.size() != 0 || i_s_tvalid || answer_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/rpe_pkg.sv
rtl/core/rpe_front.sv
rtl/core/rpe_queue.sv
rtl/core/rpe_div.sv
rtl/core/rpe_back.sv
rtl/core/postfix_expression_evaluator.sv
rtl/core/rpe_checker.sv
test/tb_top.sv
